FILE: design/ksc_pkg.sv
package ksc_pkg;

	localparam int KEY_W = 64;
	localparam int SLOT_OUT_W = 8;

	// lookup item op codes
	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_TICK   = 1'b1;

	// sequencer steps, shared by controller and datapath
	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_SCAN  = 4'd1;
	localparam logic [3:0] ST_UNL1  = 4'd2;
	localparam logic [3:0] ST_UNL2  = 4'd3;
	localparam logic [3:0] ST_LINK  = 4'd4;
	localparam logic [3:0] ST_LINK2 = 4'd5;
	localparam logic [3:0] ST_CHUNK = 4'd6;
	localparam logic [3:0] ST_POP   = 4'd7;
	localparam logic [3:0] ST_POP2  = 4'd8;
	localparam logic [3:0] ST_RESP  = 4'd9;
	localparam logic [3:0] ST_TICK0 = 4'd10;
	localparam logic [3:0] ST_TICK1 = 4'd11;
	localparam logic [3:0] ST_TWALK = 4'd12;
	localparam logic [3:0] ST_TNEXT = 4'd13;

	typedef struct packed {
		logic [3:0] step;
		logic       accept;
	} cmd_t;

	typedef struct packed {
		logic hit;
		logic scan_miss;
		logic same_frame;
		logic stack_empty;
		logic fill_left;
		logic chunk_last;
		logic head_valid;
		logic walk_null;
		logic out_free;
	} status_t;

endpackage

FILE: design/ksc_if.sv
interface ksc_lookup_if;
	logic                      valid;
	logic                      ready;
	logic                      op;
	logic [ksc_pkg::KEY_W-1:0] key;

	modport source (output valid, output op, output key, input ready);
	modport sink (input valid, input op, input key, output ready);
endinterface

interface ksc_result_if;
	logic                           valid;
	logic                           ready;
	logic [ksc_pkg::SLOT_OUT_W-1:0] slot;
	logic                           hit;
	logic                           full_res;

	modport source (output valid, output slot, output hit, output full_res, input ready);
	modport sink (input valid, input slot, input hit, input full_res, output ready);
endinterface

FILE: design/ksc_ram.sv
module ksc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: design/ksc_ctrl.sv
module ksc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_op,
	output logic               in_ready,
	input  ksc_pkg::status_t   st,
	output ksc_pkg::cmd_t      cmd
);
	logic [3:0] state_q;
	logic [3:0] state_d;

	assign in_ready   = (state_q == ksc_pkg::ST_IDLE);
	assign cmd.step   = state_q;
	assign cmd.accept = in_ready && in_valid;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ksc_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = (in_op == ksc_pkg::OP_TICK) ? ksc_pkg::ST_TICK0
						: ksc_pkg::ST_SCAN;
				end
			end
			ksc_pkg::ST_SCAN: begin
				if (st.hit) begin
					state_d = st.same_frame ? ksc_pkg::ST_RESP : ksc_pkg::ST_UNL1;
				end else if (st.scan_miss) begin
					if (!st.stack_empty) state_d = ksc_pkg::ST_POP;
					else if (st.fill_left) state_d = ksc_pkg::ST_CHUNK;
					else state_d = ksc_pkg::ST_RESP;
				end
			end
			ksc_pkg::ST_UNL1:  state_d = ksc_pkg::ST_UNL2;
			ksc_pkg::ST_UNL2:  state_d = ksc_pkg::ST_LINK;
			ksc_pkg::ST_LINK:  state_d = st.head_valid ? ksc_pkg::ST_LINK2 : ksc_pkg::ST_RESP;
			ksc_pkg::ST_LINK2: state_d = ksc_pkg::ST_RESP;
			ksc_pkg::ST_CHUNK: begin
				if (st.chunk_last) state_d = ksc_pkg::ST_POP;
			end
			ksc_pkg::ST_POP:   state_d = ksc_pkg::ST_POP2;
			ksc_pkg::ST_POP2:  state_d = ksc_pkg::ST_LINK;
			ksc_pkg::ST_RESP: begin
				if (st.out_free) state_d = ksc_pkg::ST_IDLE;
			end
			ksc_pkg::ST_TICK0: state_d = ksc_pkg::ST_TICK1;
			ksc_pkg::ST_TICK1: state_d = ksc_pkg::ST_TWALK;
			ksc_pkg::ST_TWALK: state_d = st.walk_null ? ksc_pkg::ST_IDLE : ksc_pkg::ST_TNEXT;
			ksc_pkg::ST_TNEXT: state_d = ksc_pkg::ST_TWALK;
			default:           state_d = ksc_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ksc_pkg::ST_IDLE;
		else state_q <= state_d;
	end
endmodule

FILE: design/ksc_dp.sv
module ksc_dp #(
	parameter int RING_FRAMES = 8,
	parameter int CHUNK_SLOTS = 16,
	parameter int TOTAL_SLOTS = 256
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  ksc_pkg::cmd_t                    cmd,
	input  logic [ksc_pkg::KEY_W-1:0]        in_key,
	output ksc_pkg::status_t                 st,
	output logic                             res_valid,
	input  logic                             res_ready,
	output logic [ksc_pkg::SLOT_OUT_W-1:0]   res_slot,
	output logic                             res_hit,
	output logic                             res_full
);
	localparam int SW = $clog2(TOTAL_SLOTS);
	localparam int LW = SW + 1;
	localparam int FW = $clog2(RING_FRAMES);
	localparam int CW = (CHUNK_SLOTS > 1) ? $clog2(CHUNK_SLOTS) : 1;
	localparam logic [LW-1:0] NIL = {1'b1, {SW{1'b0}}};

	logic [ksc_pkg::KEY_W-1:0] key_q;
	logic [FW-1:0] frame_now_q;
	logic [LW-1:0] free_top_q;
	logic [LW-1:0] fill_q;
	logic [CW-1:0] cnt_q;
	logic [LW-1:0] head_q [RING_FRAMES];
	logic [LW-1:0] tail_q [RING_FRAMES];
	logic          valid_q [TOTAL_SLOTS];
	logic [SW-1:0] idx_q;
	logic          issue_done_q;
	logic [SW-1:0] idx_s1;
	logic          scan_v_s1;
	logic [SW-1:0] slot_q;
	logic [FW-1:0] old_q;
	logic [LW-1:0] p_q, n_q, h_q, walk_q;
	logic          hit_q, full_q;
	logic          res_valid_q;
	logic [SW-1:0] res_slot_q;
	logic          res_hit_q, res_full_q;

	logic [ksc_pkg::KEY_W-1:0] key_rd;
	logic [FW-1:0] frame_rd;
	logic [LW-1:0] next_rd, prev_rd;
	logic [SW-1:0] stack_rd;

	logic key_we, frame_we, next_we, prev_we, stack_we;
	logic [SW-1:0] next_wa, prev_wa, stack_wa, next_ra, stack_ra;
	logic [LW-1:0] next_wd, prev_wd, top_m1;
	logic [SW-1:0] stack_wd;
	logic [LW-1:0] head_now;
	logic [SW+7:0] slot_ext;
	logic          res_load;

	assign head_now = head_q[frame_now_q];
	assign top_m1   = free_top_q - LW'(1);
	assign stack_ra = top_m1[SW-1:0];
	assign next_ra  = (cmd.step == ksc_pkg::ST_TWALK) ? walk_q[SW-1:0] : idx_q;

	// status toward the sequencer
	assign st.hit         = scan_v_s1 && valid_q[idx_s1] && (key_rd == key_q);
	assign st.scan_miss   = scan_v_s1 && (idx_s1 == SW'(TOTAL_SLOTS - 1)) && !st.hit;
	assign st.same_frame  = (frame_rd == frame_now_q);
	assign st.stack_empty = (free_top_q == '0);
	assign st.fill_left   = (fill_q < LW'(TOTAL_SLOTS));
	assign st.chunk_last  = (cnt_q == CW'(CHUNK_SLOTS - 1)) || (fill_q == LW'(TOTAL_SLOTS - 1));
	assign st.head_valid  = !head_now[SW];
	assign st.walk_null   = walk_q[SW];
	assign st.out_free    = !res_valid_q || res_ready;

	assign res_load = (cmd.step == ksc_pkg::ST_RESP) && st.out_free;

	// memory write ports
	always_comb begin
		key_we   = 1'b0;
		frame_we = 1'b0;
		next_we  = 1'b0;
		prev_we  = 1'b0;
		stack_we = 1'b0;
		next_wa  = slot_q;
		next_wd  = head_now;
		prev_wa  = slot_q;
		prev_wd  = NIL;
		stack_wa = free_top_q[SW-1:0];
		stack_wd = fill_q[SW-1:0];
		unique case (cmd.step)
			ksc_pkg::ST_UNL1: begin
				next_we = !p_q[SW];
				next_wa = p_q[SW-1:0];
				next_wd = n_q;
			end
			ksc_pkg::ST_UNL2: begin
				prev_we = !n_q[SW];
				prev_wa = n_q[SW-1:0];
				prev_wd = p_q;
			end
			ksc_pkg::ST_LINK: begin
				key_we   = !hit_q;
				frame_we = 1'b1;
				next_we  = 1'b1;
				prev_we  = 1'b1;
			end
			ksc_pkg::ST_LINK2: begin
				prev_we = 1'b1;
				prev_wa = h_q[SW-1:0];
				prev_wd = {1'b0, slot_q};
			end
			ksc_pkg::ST_CHUNK: stack_we = 1'b1;
			ksc_pkg::ST_TWALK: begin
				stack_we = !walk_q[SW] && (free_top_q < LW'(TOTAL_SLOTS));
				stack_wd = walk_q[SW-1:0];
			end
			default: ;
		endcase
	end

	ksc_ram #(.WIDTH(ksc_pkg::KEY_W), .DEPTH(TOTAL_SLOTS)) u_key_ram (
		.clk(clk), .we(key_we), .waddr(slot_q), .wdata(key_q),
		.raddr(idx_q), .rdata(key_rd)
	);
	ksc_ram #(.WIDTH(FW), .DEPTH(TOTAL_SLOTS)) u_frame_ram (
		.clk(clk), .we(frame_we), .waddr(slot_q), .wdata(frame_now_q),
		.raddr(idx_q), .rdata(frame_rd)
	);
	ksc_ram #(.WIDTH(LW), .DEPTH(TOTAL_SLOTS)) u_next_ram (
		.clk(clk), .we(next_we), .waddr(next_wa), .wdata(next_wd),
		.raddr(next_ra), .rdata(next_rd)
	);
	ksc_ram #(.WIDTH(LW), .DEPTH(TOTAL_SLOTS)) u_prev_ram (
		.clk(clk), .we(prev_we), .waddr(prev_wa), .wdata(prev_wd),
		.raddr(idx_q), .rdata(prev_rd)
	);
	ksc_ram #(.WIDTH(SW), .DEPTH(TOTAL_SLOTS)) u_stack_ram (
		.clk(clk), .we(stack_we), .waddr(stack_wa), .wdata(stack_wd),
		.raddr(stack_ra), .rdata(stack_rd)
	);

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.accept) key_q <= in_key;
		if (cmd.step == ksc_pkg::ST_SCAN && !issue_done_q) idx_s1 <= idx_q;
		if (cmd.step == ksc_pkg::ST_SCAN && st.hit) begin
			slot_q <= idx_s1;
			old_q  <= frame_rd;
			p_q    <= prev_rd;
			n_q    <= next_rd;
		end
		if (cmd.step == ksc_pkg::ST_POP2) slot_q <= stack_rd;
		if (cmd.step == ksc_pkg::ST_LINK) h_q <= head_now;
		if (cmd.step == ksc_pkg::ST_TICK1) walk_q <= head_now;
		if (cmd.step == ksc_pkg::ST_TNEXT) walk_q <= next_rd;
		if (res_load) begin
			res_slot_q <= full_q ? '0 : slot_q;
			res_hit_q  <= hit_q;
			res_full_q <= full_q;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_now_q  <= '0;
			free_top_q   <= '0;
			fill_q       <= '0;
			cnt_q        <= '0;
			idx_q        <= '0;
			issue_done_q <= 1'b0;
			scan_v_s1    <= 1'b0;
			hit_q        <= 1'b0;
			full_q       <= 1'b0;
			res_valid_q  <= 1'b0;
			for (int r = 0; r < RING_FRAMES; r++) begin
				head_q[r] <= NIL;
				tail_q[r] <= NIL;
			end
			for (int i = 0; i < TOTAL_SLOTS; i++) valid_q[i] <= 1'b0;
		end else begin
			if (res_load) res_valid_q <= 1'b1;
			else if (res_ready) res_valid_q <= 1'b0;

			if (cmd.accept) begin
				idx_q        <= '0;
				issue_done_q <= 1'b0;
				scan_v_s1    <= 1'b0;
				cnt_q        <= '0;
				hit_q        <= 1'b0;
				full_q       <= 1'b0;
			end

			unique case (cmd.step)
				ksc_pkg::ST_SCAN: begin
					scan_v_s1 <= !issue_done_q;
					if (!issue_done_q) begin
						if (idx_q == SW'(TOTAL_SLOTS - 1)) issue_done_q <= 1'b1;
						else idx_q <= idx_q + SW'(1);
					end
					if (st.hit) hit_q <= 1'b1;
					else if (st.scan_miss && st.stack_empty && !st.fill_left) full_q <= 1'b1;
				end
				ksc_pkg::ST_UNL1: begin
					if (p_q[SW]) head_q[old_q] <= n_q;
				end
				ksc_pkg::ST_UNL2: begin
					if (n_q[SW]) tail_q[old_q] <= p_q;
				end
				ksc_pkg::ST_LINK: begin
					head_q[frame_now_q] <= {1'b0, slot_q};
					if (head_now[SW]) tail_q[frame_now_q] <= {1'b0, slot_q};
					if (!hit_q) valid_q[slot_q] <= 1'b1;
				end
				ksc_pkg::ST_CHUNK: begin
					free_top_q <= free_top_q + LW'(1);
					fill_q     <= fill_q + LW'(1);
					cnt_q      <= cnt_q + CW'(1);
				end
				ksc_pkg::ST_POP: free_top_q <= top_m1;
				ksc_pkg::ST_TICK0: begin
					if (frame_now_q == FW'(RING_FRAMES - 1)) frame_now_q <= '0;
					else frame_now_q <= frame_now_q + FW'(1);
				end
				ksc_pkg::ST_TWALK: begin
					if (walk_q[SW]) begin
						head_q[frame_now_q] <= NIL;
						tail_q[frame_now_q] <= NIL;
					end else begin
						valid_q[walk_q[SW-1:0]] <= 1'b0;
						if (free_top_q < LW'(TOTAL_SLOTS)) free_top_q <= free_top_q + LW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	assign slot_ext  = {8'b0, res_slot_q};
	assign res_valid = res_valid_q;
	assign res_slot  = slot_ext[7:0];
	assign res_hit   = res_hit_q;
	assign res_full  = res_full_q;

	a_top_bound: assert property (@(posedge clk) disable iff (!arst_n)
		free_top_q <= LW'(TOTAL_SLOTS))
		else $error("free stack overflow");
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= LW'(TOTAL_SLOTS))
		else $error("fresh slot count past capacity");
	a_full_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(res_load && full_q) |-> (free_top_q == '0 && fill_q == LW'(TOTAL_SLOTS)))
		else $error("full reported with slots left");
	a_link2_head: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step == ksc_pkg::ST_LINK2) |-> !h_q[SW])
		else $error("back link to a null head");
endmodule

FILE: design/keyed_slot_cache_frame_aging.sv
// lookup: key scan (one key memory read per cycle), then relink (unlink, link) or insert (pop, link),
//   with a fresh chunk pushed onto the free stack first when the stack is empty and fresh slots are left
// tick: advance the frame, then walk its list and free each entry (one next-link memory read per entry)
// one item at a time; a finished result sits in the output register while the next item is taken
// reset (async, active low): all lists empty, valid bits cleared at once, frame 0, stack empty
module keyed_slot_cache_frame_aging #(
	parameter int RING_FRAMES = 8,
	parameter int CHUNK_SLOTS = 16,
	parameter int TOTAL_SLOTS = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	ksc_lookup_if.sink  lookup,
	ksc_result_if.source result
);
	// command and status between sequencer and datapath
	ksc_pkg::cmd_t    cmd;
	ksc_pkg::status_t st;

	// sequencer: walks scan, relink, chunk refill, pop and tick walk
	ksc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (lookup.valid),
		.in_op    (lookup.op),
		.in_ready (lookup.ready),
		.st       (st),
		.cmd      (cmd)
	);

	// datapath: key, frame, link and free stack memories plus list heads and tails
	ksc_dp #(
		.RING_FRAMES (RING_FRAMES),
		.CHUNK_SLOTS (CHUNK_SLOTS),
		.TOTAL_SLOTS (TOTAL_SLOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_key    (lookup.key),
		.st        (st),
		.res_valid (result.valid),
		.res_ready (result.ready),
		.res_slot  (result.slot),
		.res_hit   (result.hit),
		.res_full  (result.full_res)
	);
endmodule

FILE: verif/keyed_slot_cache_frame_aging_test.sv
`timescale 1ns / 100ps

module keyed_slot_cache_frame_aging_test;

	localparam int FRAMES = 8;
	localparam int CHUNK = 16;
	localparam int SLOTS = 256;
	localparam int NO_LINK = 'hFFFF;
	localparam longint CYCLE_LIMIT = 3000000;
	localparam int DRAIN_CYCLES = 600;

	typedef struct {
		logic [ksc_pkg::SLOT_OUT_W-1:0] slot;
		logic                           hit;
		logic                           full_res;
	} slot_answer_t;

	logic clk;
	logic arst_n;

	ksc_lookup_if lookup_ch ();
	ksc_result_if result_ch ();

	keyed_slot_cache_frame_aging dut (
		.clk(clk),
		.arst_n(arst_n),
		.lookup(lookup_ch),
		.result(result_ch)
	);

	// shadow copy of the cache state
	logic [ksc_pkg::KEY_W-1:0] shadow_key [SLOTS];
	bit                        shadow_valid [SLOTS];
	int                        shadow_frame [SLOTS];
	int                        shadow_next [SLOTS];
	int                        shadow_prev [SLOTS];
	int                        frame_head [FRAMES];
	int                        frame_tail [FRAMES];
	int                        free_slots [SLOTS];
	int                        free_count;
	int                        chunks_used;
	int                        cur_frame;

	slot_answer_t answers_due [$];
	logic [ksc_pkg::KEY_W-1:0] key_pool [64];

	int     error_count;
	longint cycle_count;
	int     lookups_sent, ticks_sent, answers_seen, hits_seen, fulls_seen;
	bit     idle_enable;
	int     hold_cycles;

	// clock, with the run watchdog
	initial begin
		clk = 1'b0;
		cycle_count = 0;
		forever begin
			#4 clk = ~clk;
			if (clk) begin
				cycle_count++;
				if (cycle_count > CYCLE_LIMIT) begin
					$display("timeout after %0d cycles", cycle_count);
					$display("status: fail");
					$finish;
				end
			end
		end
	end

	function automatic void shadow_reset();
		for (int i = 0; i < SLOTS; i++) begin
			shadow_valid[i] = 0;
			shadow_key[i] = '0;
			shadow_frame[i] = 0;
			shadow_next[i] = 0;
			shadow_prev[i] = 0;
			free_slots[i] = 0;
		end
		for (int f = 0; f < FRAMES; f++) begin
			frame_head[f] = NO_LINK;
			frame_tail[f] = NO_LINK;
		end
		free_count = 0;
		chunks_used = 0;
		cur_frame = 0;
	endfunction

	function automatic void free_push(int s);
		if (free_count < SLOTS) begin
			free_slots[free_count] = s;
			free_count++;
		end
	endfunction

	function automatic void frame_attach(int f, int s);
		int h;
		h = frame_head[f];
		shadow_prev[s] = NO_LINK;
		shadow_next[s] = h;
		if (h < SLOTS) shadow_prev[h] = s;
		else frame_tail[f] = s;
		frame_head[f] = s;
	endfunction

	function automatic void frame_detach(int f, int s);
		int p, n;
		p = shadow_prev[s];
		n = shadow_next[s];
		if (p < SLOTS) shadow_next[p] = n;
		else frame_head[f] = n;
		if (n < SLOTS) shadow_prev[n] = p;
		else frame_tail[f] = p;
	endfunction

	// frame advance: the new frame's list is released front to back
	function automatic void age_frame();
		int s, steps;
		steps = 0;
		cur_frame = (cur_frame + 1) % FRAMES;
		s = frame_head[cur_frame];
		while (s < SLOTS && steps < SLOTS) begin
			free_push(s);
			shadow_valid[s] = 0;
			s = shadow_next[s];
			steps++;
		end
		frame_head[cur_frame] = NO_LINK;
		frame_tail[cur_frame] = NO_LINK;
	endfunction

	function automatic slot_answer_t resolve_key(logic [ksc_pkg::KEY_W-1:0] k);
		slot_answer_t a;
		int base, s;
		for (int i = 0; i < SLOTS; i++) begin
			if (shadow_valid[i] && shadow_key[i] == k) begin
				if (shadow_frame[i] != cur_frame) begin
					frame_detach(shadow_frame[i], i);
					frame_attach(cur_frame, i);
					shadow_frame[i] = cur_frame;
				end
				a.slot = i[7:0];
				a.hit = 1'b1;
				a.full_res = 1'b0;
				return a;
			end
		end
		// refill from the next fresh chunk, ascending, so the top of it pops first
		if (free_count == 0) begin
			base = chunks_used * CHUNK;
			if (base < SLOTS) begin
				for (int i = 0; i < CHUNK && base + i < SLOTS; i++) free_push(base + i);
				chunks_used++;
			end
		end
		if (free_count == 0) begin
			a.slot = '0;
			a.hit = 1'b0;
			a.full_res = 1'b1;
			return a;
		end
		free_count--;
		s = free_slots[free_count];
		shadow_key[s] = k;
		shadow_valid[s] = 1;
		shadow_frame[s] = cur_frame;
		frame_attach(cur_frame, s);
		a.slot = s[7:0];
		a.hit = 1'b0;
		a.full_res = 1'b0;
		return a;
	endfunction

	// one monitor: predict on each accepted lookup transfer, check each result transfer
	always @(posedge clk) begin
		slot_answer_t want;
		if (arst_n && lookup_ch.valid && lookup_ch.ready) begin
			if (lookup_ch.op == ksc_pkg::OP_TICK) age_frame();
			else answers_due.insert(answers_due.size(), resolve_key(lookup_ch.key));
		end
		if (arst_n && result_ch.valid && result_ch.ready) begin
			answers_seen++;
			if (answers_due.size() == 0) begin
				$display("%0t: unexpected result slot=%0d hit=%0b full=%0b", $time,
					result_ch.slot, result_ch.hit, result_ch.full_res);
				error_count++;
			end else begin
				want = answers_due.pop_front();
				if (want.hit) hits_seen++;
				if (want.full_res) fulls_seen++;
				if (result_ch.slot !== want.slot) begin
					$display("%0t: slot expected %0d actual %0d", $time, want.slot,
						result_ch.slot);
					error_count++;
				end
				if (result_ch.hit !== want.hit) begin
					$display("%0t: hit expected %0b actual %0b", $time, want.hit,
						result_ch.hit);
					error_count++;
				end
				if (result_ch.full_res !== want.full_res) begin
					$display("%0t: full_res expected %0b actual %0b", $time,
						want.full_res, result_ch.full_res);
					error_count++;
				end
			end
		end
	end

	// result side ready: random stall bursts, or a long counted hold-off when asked
	initial begin
		int burst;
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				result_ch.ready = 1'b0;
				hold_cycles--;
			end else if (idle_enable && burst > 0) begin
				result_ch.ready = 1'b0;
				burst--;
			end else begin
				result_ch.ready = 1'b1;
				if (idle_enable && $urandom_range(0, 5) == 0) burst = $urandom_range(1, 4);
			end
		end
	end

	// one transfer on the lookup side; valid stays high until the next call or stop_lookups
	task automatic send_item(logic op_code, logic [ksc_pkg::KEY_W-1:0] k);
		@(negedge clk);
		if (idle_enable && $urandom_range(0, 5) == 0) begin
			lookup_ch.valid = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		lookup_ch.valid = 1'b1;
		lookup_ch.op = op_code;
		lookup_ch.key = k;
		do @(posedge clk); while (!lookup_ch.ready);
		if (op_code == ksc_pkg::OP_TICK) ticks_sent++;
		else lookups_sent++;
	endtask

	task automatic stop_lookups();
		@(negedge clk);
		lookup_ch.valid = 1'b0;
	endtask

	function automatic logic [ksc_pkg::KEY_W-1:0] any_key();
		return {$urandom(), $urandom()};
	endfunction

	task automatic wait_answers();
		while (answers_due.size() != 0) @(posedge clk);
	endtask

	// extremes of the key, hits in the current and in an older frame, empty tick
	task automatic test_directed();
		send_item(ksc_pkg::OP_LOOKUP, '0);
		send_item(ksc_pkg::OP_LOOKUP, '1);
		send_item(ksc_pkg::OP_LOOKUP, '0);
		send_item(ksc_pkg::OP_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA);
		send_item(ksc_pkg::OP_LOOKUP, 64'h5555_5555_5555_5555);
		send_item(ksc_pkg::OP_TICK, '0);
		send_item(ksc_pkg::OP_LOOKUP, '1);
		send_item(ksc_pkg::OP_LOOKUP, 64'h5555_5555_5555_5555);
		send_item(ksc_pkg::OP_LOOKUP, 64'h0000_0001_0000_0000);
		send_item(ksc_pkg::OP_TICK, '1);
		send_item(ksc_pkg::OP_TICK, '0);
		send_item(ksc_pkg::OP_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA);
		// ring wraps back to frame 0, releasing its remaining entries
		repeat (6) send_item(ksc_pkg::OP_TICK, any_key());
		send_item(ksc_pkg::OP_LOOKUP, '0);
		send_item(ksc_pkg::OP_LOOKUP, 64'h8000_0000_0000_0001);
		send_item(ksc_pkg::OP_LOOKUP, '1);
	endtask

	// every chunk handed out, then misses report full; a full ring flush follows
	task automatic test_fill_to_full();
		for (int i = 0; i < 270; i++) send_item(ksc_pkg::OP_LOOKUP, any_key());
		send_item(ksc_pkg::OP_LOOKUP, key_pool[0]);
		repeat (FRAMES) send_item(ksc_pkg::OP_TICK, any_key());
	endtask

	// frame-like traffic: a draw burst over a reused key set, then a tick
	task automatic test_random_frames(int count);
		int n;
		n = 0;
		while (n < count) begin
			repeat ($urandom_range(4, 30)) begin
				case ($urandom_range(0, 9))
					0, 1: send_item(ksc_pkg::OP_LOOKUP, any_key());
					default: send_item(ksc_pkg::OP_LOOKUP, key_pool[$urandom_range(0, 63)]);
				endcase
				n++;
			end
			send_item(ksc_pkg::OP_TICK, any_key());
			n++;
		end
	endtask

	// receiver holds off long enough for the block to fill up and stall its input
	task automatic test_result_hold();
		hold_cycles = 400;
		for (int i = 0; i < 40; i++) begin
			send_item(ksc_pkg::OP_LOOKUP, key_pool[$urandom_range(0, 15)]);
		end
		send_item(ksc_pkg::OP_TICK, any_key());
	endtask

	task automatic test_full_rate(int count);
		idle_enable = 1'b0;
		test_random_frames(count);
	endtask

	initial begin
		error_count = 0;
		lookups_sent = 0;
		ticks_sent = 0;
		answers_seen = 0;
		hits_seen = 0;
		fulls_seen = 0;
		hold_cycles = 0;
		idle_enable = 1'b1;
		lookup_ch.valid = 1'b0;
		lookup_ch.op = ksc_pkg::OP_LOOKUP;
		lookup_ch.key = '0;
		for (int i = 0; i < 64; i++) key_pool[i] = any_key();
		shadow_reset();
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_fill_to_full();
		test_random_frames(1250);
		test_result_hold();
		test_full_rate(300);
		stop_lookups();

		wait_answers();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d lookups and %0d frame ticks, %0d results checked", lookups_sent,
			ticks_sent, answers_seen);
		$display("of those %0d hits and %0d full reports, %0d errors", hits_seen, fulls_seen,
			error_count);
		if (error_count == 0 && answers_due.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
